### sv/fbb_pkg.sv
// ============================================================================
// fbb_pkg
// Shared widths, register indexes and command codes of the framebuffer blitter.
// ============================================================================
`default_nettype none

package fbb_pkg;

    localparam int MEM_WORDS = 65536;
    localparam int ADDR_W    = $clog2(MEM_WORDS);
    localparam int DIM_W     = 13;
    localparam int PW_W      = 16;
    localparam int PROD_W    = DIM_W + PW_W + 1;
    localparam int PIX_W     = 32;
    localparam int CRD_W     = 16;
    localparam int PADDR_W   = 4;

    localparam logic [7:0] BPP_OK = 8'd32;

    localparam logic [2:0] FN_PUT   = 3'd0;
    localparam logic [2:0] FN_FILL  = 3'd1;
    localparam logic [2:0] FN_COPY  = 3'd2;
    localparam logic [2:0] FN_GLYPH = 3'd3;
    localparam logic [2:0] FN_READ  = 3'd4;

    localparam logic [1:0] REG_FB_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FB_HEIGHT = 2'd1;
    localparam logic [1:0] REG_PITCH     = 2'd2;
    localparam logic [1:0] REG_BPP       = 2'd3;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [PIX_W-1:0]  wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage

`default_nettype wire

### sv/fbb_ifs.sv
// ============================================================================
// fbb_ifs
// Command and result channels of the framebuffer blitter.
// ============================================================================
`default_nettype none

interface fbb_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] src_x;
    logic [15:0] src_y;
    logic [15:0] rect_width;
    logic [15:0] rect_height;
    logic [31:0] color;
    logic [63:0] glyph_bits;
    logic [15:0] scale;

    modport source (output valid, func, x, y, src_x, src_y, rect_width, rect_height,
                    color, glyph_bits, scale, input ready);
    modport sink (input valid, func, x, y, src_x, src_y, rect_width, rect_height,
                  color, glyph_bits, scale, output ready);
endinterface

interface fbb_res_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [31:0] pixel_value;

    modport source (output valid, status, pixel_value, input ready);
    modport sink (input valid, status, pixel_value, output ready);
endinterface

`default_nettype wire

### sv/fbb_mem.sv
// ============================================================================
// fbb_mem
// Pixel memory: one write port, one read port with registered data.
// ============================================================================
`default_nettype none

module fbb_mem (
    input  wire                       clk,
    input  fbb_pkg::mem_req_t         req,
    output logic [fbb_pkg::PIX_W-1:0] rdata
);
    import fbb_pkg::*;

    logic [PIX_W-1:0] mem [MEM_WORDS];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

`default_nettype wire

### sv/fbb_mac.sv
// ============================================================================
// fbb_mac
// Shared multiply-add unit: row * pitch + column, registered.
// ============================================================================
`default_nettype none

module fbb_mac (
    input  wire                        clk,
    input  wire  [fbb_pkg::DIM_W-1:0]  a,
    input  wire  [fbb_pkg::PW_W-1:0]   b,
    input  wire  [fbb_pkg::DIM_W-1:0]  c,
    output logic [fbb_pkg::PROD_W-1:0] res_reg
);
    import fbb_pkg::*;

    logic [PROD_W-1:0] res_next;

    // operands widened first so the product keeps all its bits
    assign res_next = PROD_W'(a) * PROD_W'(b) + PROD_W'(c);

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

`default_nettype wire

### sv/framebuffer_blitter.sv
// ============================================================================
// framebuffer_blitter
// 32 bpp blitter with internal pixel memory: put, fill, copy, glyph, read.
// ============================================================================
// Usage:
//  - Program fb_width, fb_height, row_pitch_bytes and bits_per_pixel over the
//    APB port (byte addresses 0, 4, 8, 12) while no command is in flight.
//  - Send one command per item on cmd; cmd.ready is high only when the
//    sequencer is idle. Each command returns exactly one item on res with
//    status (0 done, 1 ignored) and pixel_value (read data for func 4).
//  - Steps: a geometry check, then per pixel written by put, fill and
//    glyph one multiply-add and one memory write, per copied pixel the
//    source address, the read and the write, a step per glyph row and
//    per glyph cell, and address, read and capture for a read. The single
//    shared multiply-add unit forms every address in turn.
//  - The result is held in the output register until res.ready; the next
//    command is accepted in the cycle after the result leaves.
//  - Reset clears the configuration registers and the sequencer; the pixel memory is
//    not cleared and holds undefined data until written.
// ============================================================================
`default_nettype none

module framebuffer_blitter (
    input  wire                          clk,
    input  wire                          rst_n,
    fbb_cmd_if.sink                      cmd,
    fbb_res_if.source                    res,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [fbb_pkg::PADDR_W-1:0]  paddr,
    input  wire  [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import fbb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_GEOM, S_DECIDE, S_FADDR, S_FWR, S_CSRC, S_CRD, S_CWR,
        S_GROW, S_GCELL, S_RD1, S_RD2, S_OUT
    } state_t;

    // ---------------- configuration registers ----------------
    logic [DIM_W-1:0] fb_width_reg, fb_height_reg;
    logic [17:0]      pitch_reg;
    logic [7:0]       bpp_reg;
    logic [PW_W-1:0]  pw;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign pw     = pitch_reg[17:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_width_reg  <= '0;
            fb_height_reg <= '0;
            pitch_reg     <= '0;
            bpp_reg       <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_FB_WIDTH:  fb_width_reg  <= pwdata[DIM_W-1:0];
                REG_FB_HEIGHT: fb_height_reg <= pwdata[DIM_W-1:0];
                REG_PITCH:     pitch_reg     <= pwdata[17:0];
                REG_BPP:       bpp_reg       <= pwdata[7:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_FB_WIDTH:  prdata = 32'(fb_width_reg);
            REG_FB_HEIGHT: prdata = 32'(fb_height_reg);
            REG_PITCH:     prdata = 32'(pitch_reg);
            REG_BPP:       prdata = 32'(bpp_reg);
            default:       prdata = '0;
        endcase
    end

    // ---------------- command latch and sequencer state ----------------
    state_t            state_reg;
    logic [2:0]        func_reg;
    logic [CRD_W-1:0]  x_reg, y_reg, sx_reg, sy_reg, w_reg, h_reg, scale_reg;
    logic [PIX_W-1:0]  color_reg;
    logic [63:0]       glyph_reg;
    logic              status_reg;
    logic [PIX_W-1:0]  pix_reg;

    // rectangle walker (put, fill, copy, glyph cells)
    logic [DIM_W-1:0]  ox_reg, oy_reg, sox_reg, soy_reg;
    logic [DIM_W-1:0]  cw_reg, ch_reg, fr_reg, fc_reg;
    logic              rows_back_reg, cols_back_reg, glyph_mode_reg;

    // glyph walker
    logic [3:0]        gr_reg, gc_reg;
    logic [19:0]       xo_reg, yo_reg;

    // ---------------- shared multiply-add unit ----------------
    logic [DIM_W-1:0]  mac_a, mac_c;
    logic [PW_W-1:0]   mac_b;
    logic [PROD_W-1:0] mac_res;

    fbb_mac u_mac (
        .clk     (clk),
        .a       (mac_a),
        .b       (mac_b),
        .c       (mac_c),
        .res_reg (mac_res)
    );

    // copy row / column after direction select
    logic [DIM_W-1:0] cp_r, cp_c;
    assign cp_r = rows_back_reg ? DIM_W'(ch_reg - 13'd1 - fr_reg) : fr_reg;
    assign cp_c = cols_back_reg ? DIM_W'(cw_reg - 13'd1 - fc_reg) : fc_reg;

    always_comb
    begin
        mac_b = pw;
        case (state_reg)
            S_IDLE:
            begin
                mac_a = DIM_W'(fb_height_reg - 13'd1);
                mac_c = fb_width_reg;
            end
            S_DECIDE:
            begin
                mac_a = y_reg[DIM_W-1:0];
                mac_c = x_reg[DIM_W-1:0];
            end
            S_FADDR, S_CRD:
            begin
                mac_a = DIM_W'(oy_reg + fr_reg);
                mac_c = DIM_W'(ox_reg + fc_reg);
                if (state_reg == S_CRD)
                begin
                    mac_a = DIM_W'(oy_reg + cp_r);
                    mac_c = DIM_W'(ox_reg + cp_c);
                end
            end
            S_CSRC:
            begin
                mac_a = DIM_W'(soy_reg + cp_r);
                mac_c = DIM_W'(sox_reg + cp_c);
            end
            default:
            begin
                mac_a = '0;
                mac_c = '0;
            end
        endcase
    end

    // ---------------- pixel memory ----------------
    mem_req_t         mreq;
    logic [PIX_W-1:0] mem_rdata;

    fbb_mem u_mem (
        .clk   (clk),
        .req   (mreq),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        mreq.we    = (state_reg == S_FWR) || (state_reg == S_CWR);
        mreq.waddr = mac_res[ADDR_W-1:0];
        mreq.wdata = (state_reg == S_CWR) ? mem_rdata : color_reg;
        mreq.re    = (state_reg == S_CRD) || (state_reg == S_RD1);
        mreq.raddr = mac_res[ADDR_W-1:0];
    end

    // ---------------- decode helpers ----------------
    logic             geom_ok, org_ok;
    logic [CRD_W-1:0] fbw16, fbh16, aw16, ah16, saw16, sah16;
    logic [CRD_W-1:0] cp_w, cp_h, fl_w, fl_h;
    logic [CRD_W-1:0] dxs, dys;

    assign geom_ok = (fb_width_reg != '0) && (fb_height_reg != '0) && (bpp_reg == BPP_OK)
                   && (pitch_reg[1:0] == 2'b00) && (pitch_reg >= {3'b000, fb_width_reg, 2'b00})
                   && (mac_res <= PROD_W'(MEM_WORDS));
    assign fbw16   = CRD_W'(fb_width_reg);
    assign fbh16   = CRD_W'(fb_height_reg);
    assign org_ok  = (func_reg <= FN_READ) && (x_reg < fbw16) && (y_reg < fbh16);
    assign aw16    = fbw16 - x_reg;
    assign ah16    = fbh16 - y_reg;
    assign saw16   = fbw16 - sx_reg;
    assign sah16   = fbh16 - sy_reg;
    assign fl_w    = (w_reg < aw16) ? w_reg : aw16;
    assign fl_h    = (h_reg < ah16) ? h_reg : ah16;
    assign cp_w    = (fl_w < saw16) ? fl_w : saw16;
    assign cp_h    = (fl_h < sah16) ? fl_h : sah16;
    assign dxs     = x_reg - sx_reg;
    assign dys     = y_reg - sy_reg;

    // glyph cell
    logic [19:0] gaw, gah, g_cw, g_ch;
    logic        gbit;
    assign gaw  = 20'(aw16);
    assign gah  = 20'(ah16);
    assign gbit = glyph_reg[{gr_reg[2:0], ~gc_reg[2:0]}];
    assign g_cw = ((gaw - xo_reg) < 20'(scale_reg)) ? (gaw - xo_reg) : 20'(scale_reg);
    assign g_ch = ((gah - yo_reg) < 20'(scale_reg)) ? (gah - yo_reg) : 20'(scale_reg);

    logic last_c, last_r;
    assign last_c = (fc_reg == DIM_W'(cw_reg - 13'd1));
    assign last_r = (fr_reg == DIM_W'(ch_reg - 13'd1));

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            status_reg     <= 1'b0;
            pix_reg        <= '0;
            glyph_mode_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd.valid)
                    begin
                        func_reg  <= cmd.func;
                        x_reg     <= cmd.x;
                        y_reg     <= cmd.y;
                        sx_reg    <= cmd.src_x;
                        sy_reg    <= cmd.src_y;
                        w_reg     <= cmd.rect_width;
                        h_reg     <= cmd.rect_height;
                        color_reg <= cmd.color;
                        glyph_reg <= cmd.glyph_bits;
                        scale_reg <= cmd.scale;
                        state_reg <= S_GEOM;
                    end
                end
                S_GEOM:
                begin
                    // mac_res holds last visible word + 1
                    status_reg     <= 1'b1;
                    pix_reg        <= '0;
                    glyph_mode_reg <= 1'b0;
                    fr_reg         <= '0;
                    fc_reg         <= '0;
                    ox_reg         <= x_reg[DIM_W-1:0];
                    oy_reg         <= y_reg[DIM_W-1:0];
                    sox_reg        <= sx_reg[DIM_W-1:0];
                    soy_reg        <= sy_reg[DIM_W-1:0];
                    rows_back_reg  <= 1'b0;
                    cols_back_reg  <= 1'b0;
                    state_reg      <= (geom_ok && org_ok) ? S_DECIDE : S_OUT;
                end
                S_DECIDE:
                begin
                    state_reg <= S_OUT;
                    case (func_reg)
                        FN_PUT:
                        begin
                            cw_reg     <= 13'd1;
                            ch_reg     <= 13'd1;
                            status_reg <= 1'b0;
                            state_reg  <= S_FADDR;
                        end
                        FN_FILL:
                        begin
                            if (w_reg != '0 && h_reg != '0)
                            begin
                                cw_reg     <= fl_w[DIM_W-1:0];
                                ch_reg     <= fl_h[DIM_W-1:0];
                                status_reg <= 1'b0;
                                state_reg  <= S_FADDR;
                            end
                        end
                        FN_COPY:
                        begin
                            if (w_reg != '0 && h_reg != '0 && sx_reg < fbw16 && sy_reg < fbh16)
                            begin
                                cw_reg        <= cp_w[DIM_W-1:0];
                                ch_reg        <= cp_h[DIM_W-1:0];
                                rows_back_reg <= (y_reg > sy_reg) && (dys < cp_h);
                                cols_back_reg <= (sy_reg == y_reg) && (x_reg > sx_reg)
                                               && (dxs < cp_w);
                                status_reg    <= 1'b0;
                                state_reg     <= S_CSRC;
                            end
                        end
                        FN_GLYPH:
                        begin
                            if (scale_reg != '0)
                            begin
                                gr_reg         <= '0;
                                gc_reg         <= '0;
                                xo_reg         <= '0;
                                yo_reg         <= '0;
                                glyph_mode_reg <= 1'b1;
                                status_reg     <= 1'b0;
                                state_reg      <= S_GROW;
                            end
                        end
                        FN_READ:
                        begin
                            status_reg <= 1'b0;
                            state_reg  <= S_RD1;
                        end
                        default: ;
                    endcase
                end
                S_FADDR:
                begin
                    state_reg <= S_FWR;
                end
                S_FWR:
                begin
                    state_reg <= S_FADDR;
                    if (last_c)
                    begin
                        fc_reg <= '0;
                        if (last_r)
                        begin
                            state_reg <= glyph_mode_reg ? S_GCELL : S_OUT;
                        end
                        else
                        begin
                            fr_reg <= fr_reg + 13'd1;
                        end
                    end
                    else
                    begin
                        fc_reg <= fc_reg + 13'd1;
                    end
                end
                S_CSRC:
                begin
                    state_reg <= S_CRD;
                end
                S_CRD:
                begin
                    state_reg <= S_CWR;
                end
                S_CWR:
                begin
                    state_reg <= S_CSRC;
                    if (last_c)
                    begin
                        fc_reg <= '0;
                        if (last_r)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            fr_reg <= fr_reg + 13'd1;
                        end
                    end
                    else
                    begin
                        fc_reg <= fc_reg + 13'd1;
                    end
                end
                S_GROW:
                begin
                    state_reg <= (gr_reg[3] || yo_reg >= gah) ? S_OUT : S_GCELL;
                end
                S_GCELL:
                begin
                    if (gc_reg[3])
                    begin
                        gr_reg    <= gr_reg + 4'd1;
                        gc_reg    <= '0;
                        xo_reg    <= '0;
                        yo_reg    <= yo_reg + 20'(scale_reg);
                        state_reg <= S_GROW;
                    end
                    else
                    begin
                        gc_reg <= gc_reg + 4'd1;
                        xo_reg <= xo_reg + 20'(scale_reg);
                        if (gbit && xo_reg < gaw)
                        begin
                            ox_reg    <= DIM_W'(20'(x_reg) + xo_reg);
                            oy_reg    <= DIM_W'(20'(y_reg) + yo_reg);
                            cw_reg    <= g_cw[DIM_W-1:0];
                            ch_reg    <= g_ch[DIM_W-1:0];
                            fr_reg    <= '0;
                            fc_reg    <= '0;
                            state_reg <= S_FADDR;
                        end
                    end
                end
                S_RD1:
                begin
                    state_reg <= S_RD2;
                end
                S_RD2:
                begin
                    pix_reg   <= mem_rdata;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (res.ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cmd.ready       = (state_reg == S_IDLE);
    assign res.valid       = (state_reg == S_OUT);
    assign res.status      = status_reg;
    assign res.pixel_value = pix_reg;

    // ---------------- assertions ----------------
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> !cmd.ready)
        else $error("command accepted while busy");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !cmd.ready)
        else $error("result pending while ready for a command");

    a_ignored_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.status) |-> (res.pixel_value == '0))
        else $error("ignored command returned pixel data");

    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mreq.we |-> (!cmd.ready && !res.valid))
        else $error("memory write outside a command");

endmodule

`default_nettype wire
